FILE: rtl/core/flc_pkg.sv
package flc_pkg;

    localparam int NUM_PROC = 256;
    localparam int PID_W    = $clog2(NUM_PROC);
    localparam int CNT_W    = PID_W + 1;
    localparam int ACC_W    = 32;
    localparam int TMR_W    = 32;
    localparam logic [TMR_W-1:0] HOLD_LIMIT_RST = 32'd10000;

    typedef enum logic [1:0] {
        CMD_REQ  = 2'd0,
        CMD_REL  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_BAD  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_QUEUED  = 3'd1,
        EV_GRANTED = 3'd2,
        EV_RELEASE = 3'd3,
        EV_TIMEOUT = 3'd4,
        EV_PENDING = 3'd5,
        EV_IGNORED = 3'd6,
        EV_RSVD    = 3'd7
    } t_event;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd             cmd;
        logic [PID_W-1:0] pid;
    } t_item;

endpackage

FILE: rtl/core/flc_front.sv
module flc_front import flc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_pid,
    output logic        o_item_valid,
    output t_item       o_item,
    input  logic        i_item_pop
);

    // two-entry queue between intake and execution
    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_cnt;
    logic        push;
    logic        pop;
    t_item       item_in;

    always_comb begin
        item_in.cmd = t_cmd'(i_cmd);
        item_in.pid = i_pid[PID_W-1:0];
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: rtl/core/flc_back.sv
module flc_back import flc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [31:0]      i_cfg_wr_data,
    input  logic             i_item_valid,
    input  t_item            i_item,
    output logic             o_item_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [63:0]      o_data,
    output logic [2:0]       o_event
);

    t_state r_state, n_state;

    logic [PID_W-1:0] wq_mem  [NUM_PROC];
    logic [ACC_W-1:0] acc_mem [NUM_PROC];

    logic [NUM_PROC-1:0] r_active, n_active;
    logic [NUM_PROC-1:0] r_pend,   n_pend;
    logic [NUM_PROC-1:0] r_acc_vld;

    logic [PID_W-1:0] r_head, n_head;
    logic [PID_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PID_W-1:0] r_holder, n_holder;
    logic [TMR_W-1:0] r_timer, n_timer;
    logic [TMR_W-1:0] r_limit;

    t_item            r_item;
    logic [ACC_W-1:0] r_acc_rd;
    logic [PID_W-1:0] r_next_rd;

    logic             r_out_valid;
    logic [63:0]      r_out_data;
    t_event           r_out_event;

    logic             take;
    logic             go;
    logic             grant;
    logic [PID_W-1:0] grant_id;
    t_event           ev;
    logic [ACC_W-1:0] acc_cur;
    logic [ACC_W-1:0] acc_new;
    logic [ACC_W-1:0] acc_out;
    logic             acc_we;
    logic             wq_we;
    logic [TMR_W-1:0] tmr_inc;

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = i_item_valid ? ST_EXEC : ST_IDLE;
            ST_EXEC: n_state = (!r_out_valid || i_ready) ? ST_IDLE : ST_EXEC;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        take = 1'b0;
        go   = 1'b0;
        case (r_state)
            ST_IDLE: take = i_item_valid;
            ST_EXEC: go   = !r_out_valid || i_ready;
            default: begin
                take = 1'b0;
                go   = 1'b0;
            end
        endcase
    end

    assign o_item_pop = take;

    assign acc_cur = r_acc_vld[r_item.pid] ? r_acc_rd : '0;
    assign acc_new = (acc_cur == '1) ? acc_cur : acc_cur + 1'b1;
    assign tmr_inc = (r_timer == '1) ? r_timer : r_timer + 1'b1;

    always_comb begin
        n_active = r_active;
        n_pend   = r_pend;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_holder = r_holder;
        n_timer  = r_timer;
        grant    = 1'b0;
        grant_id = '0;
        ev       = EV_NONE;
        acc_we   = 1'b0;
        wq_we    = 1'b0;
        acc_out  = '0;
        case (r_item.cmd)
            CMD_REQ: begin
                acc_out = acc_cur;
                if (r_active[r_item.pid] || r_count[CNT_W-1]) begin
                    ev = EV_IGNORED;
                end else begin
                    n_active[r_item.pid] = 1'b1;
                    n_pend[r_item.pid]   = 1'b0;
                    acc_we  = 1'b1;
                    acc_out = acc_new;
                    wq_we   = 1'b1;
                    n_tail  = r_tail + 1'b1;
                    n_count = r_count + 1'b1;
                    if (r_count == '0) begin
                        grant    = 1'b1;
                        grant_id = r_item.pid;
                        n_holder = r_item.pid;
                        n_timer  = '0;
                        ev       = EV_GRANTED;
                    end else begin
                        ev = EV_QUEUED;
                    end
                end
            end
            CMD_REL: begin
                acc_out = acc_cur;
                if (!r_active[r_item.pid]) begin
                    ev = EV_IGNORED;
                end else if (r_count != '0 && r_holder == r_item.pid) begin
                    ev = EV_RELEASE;
                end else begin
                    n_pend[r_item.pid] = 1'b1;
                    ev = EV_NONE;
                end
            end
            CMD_TICK: begin
                if (r_count != '0) begin
                    if (r_pend[r_holder]) begin
                        ev = EV_PENDING;
                    end else begin
                        n_timer = tmr_inc;
                        if (tmr_inc >= r_limit) ev = EV_TIMEOUT;
                    end
                end
            end
            default: ev = EV_IGNORED;
        endcase

        // holder leaves; next in line, if any, takes over
        if (ev == EV_RELEASE || ev == EV_PENDING || ev == EV_TIMEOUT) begin
            n_active[r_holder] = 1'b0;
            n_pend[r_holder]   = 1'b0;
            n_head  = r_head + 1'b1;
            n_count = r_count - 1'b1;
            if (r_count != CNT_W'(1)) begin
                grant    = 1'b1;
                grant_id = r_next_rd;
                n_holder = r_next_rd;
                n_timer  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item    <= i_item;
            r_acc_rd  <= acc_mem[i_item.pid];
            r_next_rd <= wq_mem[r_head + 1'b1];
        end
        if (go && wq_we)  wq_mem[r_tail]       <= r_item.pid;
        if (go && acc_we) acc_mem[r_item.pid]  <= acc_new;
        if (go) begin
            r_out_data  <= {5'd0, acc_out, n_count,
                            (n_count != '0) ? n_holder : {PID_W{1'b0}},
                            (n_count != '0), grant_id, grant};
            r_out_event <= ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= '0;
            r_pend      <= '0;
            r_acc_vld   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_holder    <= '0;
            r_timer     <= '0;
            r_limit     <= HOLD_LIMIT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_limit <= i_cfg_wr_data;
            if (go) begin
                r_active <= n_active;
                r_pend   <= n_pend;
                r_head   <= n_head;
                r_tail   <= n_tail;
                r_count  <= n_count;
                r_holder <= n_holder;
                r_timer  <= n_timer;
                if (acc_we) r_acc_vld[r_item.pid] <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_event = r_out_event;

endmodule

FILE: rtl/core/fifo_lock_coordinator_core.sv
// Lock coordinator with FIFO wait queue.
// A beat passes the input queue and the item register; its result is
// registered once the output is free. A new beat waits until the last is
// executed, set by the read-then-update of the queue and access-count
// memories. Reset: synchronous, active low; queue empty, flags and counts
// cleared, hold limit 10000; no clearing pass, beats are accepted at once.
module fifo_lock_coordinator_core import flc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] process_id
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] grant_valid, [8:1] grant_id, [9] holder_valid, [17:10] holder_id,
    // [26:18] queue_length, [58:27] access_count, [63:59] zero
    output logic [63:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser   // [2:0] event_res
);

    logic  item_valid;
    t_item item;
    logic  item_pop;

    flc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_pid        (s_axis_tdata),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    flc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_item_pop    (item_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_event       (m_axis_tuser)
    );

endmodule

FILE: tb/fifo_lock_coordinator_core_test.sv
module fifo_lock_coordinator_core_test;
    import flc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] process_id
    logic [1:0]  s_axis_tuser;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [0] grant_valid, [8:1] grant_id, [9] holder_valid, [17:10] holder_id,
    // [26:18] queue_length, [58:27] access_count, [63:59] zero
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;   // [2:0] event_res

    fifo_lock_coordinator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    typedef struct packed {
        logic [31:0] acc;
        logic [8:0]  qlen;
        logic [7:0]  holder;
        logic        holder_v;
        logic [7:0]  grant;
        logic        grant_v;
    } t_lock_status;

    typedef struct {
        t_lock_status st;
        t_event       ev;
    } t_lock_result;

    // shadow copy of the coordinator
    logic [7:0]        sh_queue [NUM_PROC];
    logic [7:0]        sh_head, sh_tail;
    logic [8:0]        sh_count;
    logic              sh_active [NUM_PROC];
    logic              sh_pend [NUM_PROC];
    logic [31:0]       sh_acc [NUM_PROC];
    logic [31:0]       sh_timer;
    logic [31:0]       sh_limit;

    t_lock_result      expected_q[$];
    int                mismatches;
    int                results_seen;
    int                grants_seen;
    int                evictions_seen;
    int                send_idle_pct, recv_idle_pct;
    bit                hold_off;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void lock_reset();
        for (int i = 0; i < NUM_PROC; i++) begin
            sh_queue[i] = '0;
            sh_active[i] = 1'b0;
            sh_pend[i] = 1'b0;
            sh_acc[i] = '0;
        end
        sh_head = '0;
        sh_tail = '0;
        sh_count = '0;
        sh_timer = '0;
        sh_limit = HOLD_LIMIT_RST;
    endfunction

    function automatic void pop_holder(ref t_lock_result r);
        logic [7:0] old;
        old = sh_queue[sh_head];
        sh_active[old] = 1'b0;
        sh_pend[old] = 1'b0;
        sh_head = sh_head + 8'd1;
        sh_count = sh_count - 9'd1;
        if (sh_count != 0) begin
            r.st.grant_v = 1'b1;
            r.st.grant = sh_queue[sh_head];
            sh_timer = '0;
        end
    endfunction

    function automatic t_lock_result lock_step(t_cmd cmd, logic [7:0] pid);
        t_lock_result r;
        r.st = '0;
        r.ev = EV_NONE;
        case (cmd)
            CMD_REQ: begin
                if (sh_active[pid] || sh_count >= NUM_PROC) begin
                    r.ev = EV_IGNORED;
                end else begin
                    sh_active[pid] = 1'b1;
                    sh_pend[pid] = 1'b0;
                    if (sh_acc[pid] != 32'hFFFF_FFFF) sh_acc[pid] = sh_acc[pid] + 1;
                    if (sh_count == 0) begin
                        r.st.grant_v = 1'b1;
                        r.st.grant = pid;
                        sh_timer = '0;
                        r.ev = EV_GRANTED;
                    end else begin
                        r.ev = EV_QUEUED;
                    end
                    sh_queue[sh_tail] = pid;
                    sh_tail = sh_tail + 8'd1;
                    sh_count = sh_count + 9'd1;
                end
            end
            CMD_REL: begin
                if (!sh_active[pid]) begin
                    r.ev = EV_IGNORED;
                end else if (sh_count != 0 && sh_queue[sh_head] == pid) begin
                    pop_holder(r);
                    r.ev = EV_RELEASE;
                end else begin
                    sh_pend[pid] = 1'b1;
                end
            end
            CMD_TICK: begin
                if (sh_count != 0) begin
                    if (sh_pend[sh_queue[sh_head]]) begin
                        pop_holder(r);
                        r.ev = EV_PENDING;
                    end else begin
                        if (sh_timer != 32'hFFFF_FFFF) sh_timer = sh_timer + 1;
                        if (sh_timer >= sh_limit) begin
                            pop_holder(r);
                            r.ev = EV_TIMEOUT;
                        end
                    end
                end
            end
            default: r.ev = EV_IGNORED;
        endcase
        if (cmd == CMD_REQ || cmd == CMD_REL) r.st.acc = sh_acc[pid];
        r.st.holder_v = (sh_count != 0);
        r.st.holder = (sh_count != 0) ? sh_queue[sh_head] : 8'd0;
        r.st.qlen = sh_count;
        return r;
    endfunction

    // drive one beat; returns once accepted, tvalid left high
    task automatic send_beat(t_cmd cmd, logic [7:0] pid);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= pid;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_q.insert(expected_q.size(), lock_step(cmd, pid));
        @(negedge i_clk);
    endtask

    // send with an expectation typed in by hand as well
    task automatic send_known(t_cmd cmd, logic [7:0] pid, t_event ev, logic [8:0] qlen,
                              logic [31:0] acc);
        t_lock_result r;
        send_beat(cmd, pid);
        r = expected_q[$];
        if (r.ev != ev || r.st.qlen != qlen || r.st.acc != acc) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row off: cmd %0d pid %0d exp ev %0d q %0d acc %0d, got ev %0d q %0d acc %0d",
                         cmd, pid, ev, qlen, acc, r.ev, r.st.qlen, r.st.acc);
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [31:0] v);
        wait_drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sh_limit = v;
    endtask

    always @(posedge i_clk) begin
        t_lock_result e;
        t_lock_status got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[58:0];
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                e = expected_q.pop_front();
                if (e.st.grant_v) grants_seen++;
                if (e.ev == EV_TIMEOUT) evictions_seen++;
                if (got !== e.st || m_axis_tuser !== e.ev || m_axis_tdata[63:59] !== 5'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h ev %0d, got %h ev %0d",
                                 e.st, e.ev, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end

    typedef struct {
        t_cmd       cmd;
        logic [7:0] pid;
        t_event     ev;
        logic [8:0] qlen;
        logic [31:0] acc;
    } t_row;

    t_row table_rows[] = '{
        '{CMD_TICK, 8'd0,   EV_NONE,    9'd0, 32'd0},
        '{CMD_REL,  8'd5,   EV_IGNORED, 9'd0, 32'd0},
        '{CMD_REQ,  8'd0,   EV_GRANTED, 9'd1, 32'd1},
        '{CMD_REQ,  8'd0,   EV_IGNORED, 9'd1, 32'd1},
        '{CMD_REQ,  8'd255, EV_QUEUED,  9'd2, 32'd1},
        '{CMD_REQ,  8'd170, EV_QUEUED,  9'd3, 32'd1},
        '{CMD_BAD,  8'd85,  EV_IGNORED, 9'd3, 32'd0},
        '{CMD_REL,  8'd255, EV_NONE,    9'd3, 32'd1},
        '{CMD_REL,  8'd255, EV_NONE,    9'd3, 32'd1},
        '{CMD_REL,  8'd0,   EV_RELEASE, 9'd2, 32'd1},
        '{CMD_TICK, 8'd0,   EV_PENDING, 9'd1, 32'd0},
        '{CMD_TICK, 8'd0,   EV_NONE,    9'd1, 32'd0},
        '{CMD_REQ,  8'd85,  EV_QUEUED,  9'd2, 32'd1},
        '{CMD_TICK, 8'd3,   EV_TIMEOUT, 9'd1, 32'd0},
        '{CMD_TICK, 8'd0,   EV_NONE,    9'd1, 32'd0},
        '{CMD_REL,  8'd85,  EV_RELEASE, 9'd0, 32'd1},
        '{CMD_REQ,  8'd0,   EV_GRANTED, 9'd1, 32'd2}
    };

    task automatic random_phase(int n, int pid_span);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 38) send_beat(CMD_REQ, 8'($urandom_range(pid_span)));
            else if (r < 60) begin
                // mostly release the current holder
                if (sh_count != 0 && $urandom_range(2) != 0) send_beat(CMD_REL, sh_queue[sh_head]);
                else send_beat(CMD_REL, 8'($urandom_range(pid_span)));
            end else if (r < 97) send_beat(CMD_TICK, 8'($urandom));
            else send_beat(CMD_BAD, 8'($urandom));
        end
    endtask

    initial begin
        lock_reset();
        mismatches = 0;
        results_seen = 0;
        grants_seen = 0;
        evictions_seen = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_REQ;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // long stall so the block backs up into its input
        hold_off = 1'b1;
        fork
            begin
                repeat (60) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 12; i++) send_beat(CMD_TICK, 8'($urandom));
        join
        write_limit(32'd2);
        for (int i = 0; i < table_rows.size(); i++)
            send_known(table_rows[i].cmd, table_rows[i].pid, table_rows[i].ev,
                       table_rows[i].qlen, table_rows[i].acc);

        send_idle_pct = 26;
        recv_idle_pct = 81;
        write_limit(32'd3);
        random_phase(300, 15);
        send_idle_pct = 81;
        recv_idle_pct = 26;
        write_limit(32'hFFFF_FFFF);
        random_phase(300, 255);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(32'd7);
        random_phase(250, 31);
        // fill the queue to the top: every pid requests with no release
        write_limit(32'd10000);
        for (int p = 0; p < NUM_PROC; p++) send_beat(CMD_REQ, 8'(p));
        send_beat(CMD_REQ, 8'd7);
        write_limit(32'd2);
        random_phase(60, 255);

        wait_drain();
        $display("%0d results checked, %0d grants, %0d timeout evictions, hold limits 2..2^32-1",
                 results_seen, grants_seen, evictions_seen);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
